// ----- sv/assert_macros.svh -----
// Assertion macros used by the top level of the write framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sewf_pkg.sv -----
// Shared types, constants and the CRC-8 step function of the write framer.
`default_nettype none

package sewf_pkg;

  localparam int unsigned DEV_ADDR_W = 7;
  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CMD_EEPROM_BASE = 8'h10;
  localparam logic [ADDR_W-1:0] ADDR_LIMIT      = 8'h03;
  localparam logic [3:0]        ADDR_NIBBLE     = 4'hF;
  localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h07;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_EEPROM = 2'd1,
    ST_PROTECTED  = 2'd2,
    ST_NOT_READY  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS = 1'b0,
    REG_SENSOR_READY   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  cmd;
    logic [BYTE_W-1:0]  lo;
    logic [BYTE_W-1:0]  hi;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One byte of CRC-8, polynomial 0x07, most significant bit first.
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sewf_if.sv -----
// Valid/ready channel interfaces for write requests and bus byte words.
`default_nettype none

interface sewf_req_if;
  logic                          valid;
  logic                          ready;
  logic                          access_kind;
  logic [sewf_pkg::ADDR_W-1:0]   word_address;
  logic [sewf_pkg::VALUE_W-1:0]  word_value;

  modport source (output valid, access_kind, word_address, word_value, input ready);
  modport sink   (input valid, access_kind, word_address, word_value, output ready);
endinterface

interface sewf_res_if;
  logic                          valid;
  logic                          ready;
  logic [sewf_pkg::BYTE_W-1:0]   bus_byte;
  logic                          frame_end;
  logic                          last;
  logic [sewf_pkg::STATUS_W-1:0] status;

  modport source (output valid, bus_byte, frame_end, last, status, input ready);
  modport sink   (input valid, bus_byte, frame_end, last, status, output ready);
endinterface

`default_nettype wire

// ----- sv/sewf_front.sv -----
// Front end: accepts write requests, checks them and builds a job for the queue.
`default_nettype none

module sewf_front (
  sewf_req_if.sink                 req,
  input  wire logic                sensor_ready,
  input  wire sewf_pkg::q_stat_t   q_stat,
  output logic                     push,
  output sewf_pkg::job_t           job
);

  assign req.ready = !q_stat.full;
  assign push      = req.valid && req.ready;

  always_comb begin
    priority if (req.access_kind) begin
      job.status = sewf_pkg::ST_NOT_EEPROM;
    end else if (req.word_address > sewf_pkg::ADDR_LIMIT) begin
      job.status = sewf_pkg::ST_PROTECTED;
    end else if (!sensor_ready) begin
      job.status = sewf_pkg::ST_NOT_READY;
    end else begin
      job.status = sewf_pkg::ST_OK;
    end
    job.cmd = sewf_pkg::CMD_EEPROM_BASE | {4'h0, req.word_address[3:0] & sewf_pkg::ADDR_NIBBLE};
    job.lo  = req.word_value[7:0];
    job.hi  = req.word_value[15:8];
  end

endmodule

`default_nettype wire

// ----- sv/sewf_queue.sv -----
// Short job queue between the front end and the byte sequencer.
`default_nettype none

module sewf_queue #(
  parameter int unsigned Depth = sewf_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire sewf_pkg::job_t      push_job,
  input  wire logic                pop,
  output sewf_pkg::job_t           head_job,
  output sewf_pkg::q_stat_t        q_stat
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sewf_pkg::job_t  mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  assign head_job     = mem[rd_ptr];
  assign q_stat.full  = (count == CntW'(Depth));
  assign q_stat.empty = (count == '0);

endmodule

`default_nettype wire

// ----- sv/sewf_back.sv -----
// Byte sequencer: turns queued jobs into erase and write frames with PEC.
`default_nettype none

module sewf_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [sewf_pkg::DEV_ADDR_W-1:0] device_address,
  input  wire sewf_pkg::job_t                  head_job,
  input  wire sewf_pkg::q_stat_t               q_stat,
  output logic                                 pop,
  sewf_res_if.source                           res
);

  logic [sewf_pkg::BYTE_W-1:0]   seed;
  logic [sewf_pkg::BYTE_W-1:0]   crc;
  logic [2:0]                    idx;
  logic                          out_valid;
  logic [sewf_pkg::BYTE_W-1:0]   out_byte;
  logic                          out_frame_end;
  logic                          out_last;
  logic [sewf_pkg::STATUS_W-1:0] out_status;

  logic                          load;
  logic                          is_err;
  logic [sewf_pkg::BYTE_W-1:0]   byte_sel;
  logic                          crc_upd;
  logic [sewf_pkg::BYTE_W-1:0]   crc_next;

  // The address byte is the same for every frame, so its CRC is kept ready.
  always_ff @(posedge clk) begin
    seed <= sewf_pkg::crc8_byte('0, {device_address, 1'b0});
  end

  always_comb begin
    load   = !q_stat.empty && (!out_valid || res.ready);
    is_err = (head_job.status != sewf_pkg::ST_OK);
    unique case (idx)
      3'd0, 3'd4: byte_sel = head_job.cmd;
      3'd1, 3'd2: byte_sel = '0;
      3'd5:       byte_sel = head_job.lo;
      3'd6:       byte_sel = head_job.hi;
      default:    byte_sel = crc;
    endcase
    crc_upd  = load && !is_err && (idx[1:0] != 2'd3);
    crc_next = sewf_pkg::crc8_byte((idx[1:0] == 2'd0) ? seed : crc, byte_sel);
    pop      = load && (is_err || idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (load && !is_err) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (crc_upd) begin
      crc <= crc_next;
    end
    if (load) begin
      out_byte      <= is_err ? '0 : byte_sel;
      out_frame_end <= !is_err && (idx[1:0] == 2'd3);
      out_last      <= is_err || (idx == 3'd7);
      out_status    <= head_job.status;
    end
  end

  assign res.valid     = out_valid;
  assign res.bus_byte  = out_byte;
  assign res.frame_end = out_frame_end;
  assign res.last      = out_last;
  assign res.status    = out_status;

endmodule

`default_nettype wire

// ----- sv/smbus_eeprom_write_framer.sv -----
// Top level of the SMBus EEPROM write framer: configuration, front end, queue and sequencer.
//
// The req channel takes one write request per word: access kind, word address and value.
// The res channel gives the bus bytes, one per word, each with frame_end, last and status.
// A valid request yields eight words: the erase frame (command, 0, 0, PEC) and then the
// write frame (command, low byte, high byte, PEC); frame_end marks each PEC byte and last
// the final one. A rejected request yields one word with bus_byte 0, last 1 and the status.
// The cfg port writes device_address (index 0) and sensor_ready (index 1); it is to be
// written only while no request is in flight, and the block does not enforce this.
// The first word of a request passes through the queue and then the output register.
// The sequencer sends one byte per cycle while the receiver is ready and a job is queued;
// the front end keeps taking requests into the queue (QueueDepth entries) while the
// sequencer works. If the receiver stalls, the output word holds and the sequencer waits;
// once the queue fills, req.ready falls. Reset empties the queue and the output register
// and clears both configuration registers, so writes are rejected until sensor_ready is set.
`default_nettype none

`include "assert_macros.svh"

module smbus_eeprom_write_framer #(
  parameter int unsigned QueueDepth = sewf_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sewf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sewf_pkg::CFG_DATA_W-1:0] cfg_data,
  sewf_req_if.sink                             req,
  sewf_res_if.source                           res
);

  logic [sewf_pkg::DEV_ADDR_W-1:0] device_address;
  logic                            sensor_ready;

  logic                            push;
  logic                            pop;
  sewf_pkg::job_t                  push_job;
  sewf_pkg::job_t                  head_job;
  sewf_pkg::q_stat_t               q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= '0;
      sensor_ready   <= 1'b0;
    end else if (cfg_we) begin
      unique case (sewf_pkg::cfg_reg_t'(cfg_index))
        sewf_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data[sewf_pkg::DEV_ADDR_W-1:0];
        sewf_pkg::REG_SENSOR_READY:   sensor_ready   <= cfg_data[0];
      endcase
    end
  end

  sewf_front u_front (
    .req          (req),
    .sensor_ready (sensor_ready),
    .q_stat       (q_stat),
    .push         (push),
    .job          (push_job)
  );

  sewf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  sewf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .head_job       (head_job),
    .q_stat         (q_stat),
    .pop            (pop),
    .res            (res)
  );

  `ASSERT_IMPLIES(a_err_word, clk, rst, res.valid && res.status != sewf_pkg::ST_OK, res.last && !res.frame_end && res.bus_byte == '0, "error word is not a single zero word")
  `ASSERT_IMPLIES(a_ok_last_ends_frame, clk, rst, res.valid && res.last && res.status == sewf_pkg::ST_OK, res.frame_end, "final word of a valid request does not end a frame")
  `ASSERT_NEXT(a_pop_shows_word, clk, rst, pop, res.valid && res.last, "finished job left no final word on the output")

endmodule

`default_nettype wire

// ----- test/smbus_eeprom_write_framer_test.sv -----
// Self-checking testbench for the SMBus EEPROM write framer with random flow control.
`timescale 1ns / 1ps

module smbus_eeprom_write_framer_test;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS  = 37;

  typedef logic [sewf_pkg::BYTE_W-1:0]     byte_t;
  typedef logic [sewf_pkg::ADDR_W-1:0]     addr_t;
  typedef logic [sewf_pkg::VALUE_W-1:0]    value_t;
  typedef logic [sewf_pkg::DEV_ADDR_W-1:0] dev_t;
  typedef logic [sewf_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    byte_t             bus_byte;
    logic              frame_end;
    logic              last;
    sewf_pkg::status_t status;
  } bus_word_t;

  class write_frame_ledger;
    dev_t        dev_addr;
    logic        link_up;
    bus_word_t   pending_words[$];
    int unsigned mismatch_count;

    function new();
      dev_addr = '0;
      link_up = 1'b0;
      mismatch_count = 0;
    endfunction

    function byte_t crc_step(byte_t crc, byte_t b);
      byte_t v;
      v = crc ^ b;
      for (int i = 0; i < sewf_pkg::BYTE_W; i++) begin
        v = v[sewf_pkg::BYTE_W-1] ? ((v << 1) ^ sewf_pkg::CRC_POLY) : (v << 1);
      end
      return v;
    endfunction

    function byte_t pec(byte_t cmd, byte_t lo, byte_t hi);
      byte_t c;
      c = crc_step(8'h00, {dev_addr, 1'b0});
      c = crc_step(c, cmd);
      c = crc_step(c, lo);
      return crc_step(c, hi);
    endfunction

    function void note_request(logic kind, addr_t addr, value_t value);
      sewf_pkg::status_t st;
      byte_t             cmd;
      byte_t             frame [8];
      bus_word_t         w;
      if (kind) st = sewf_pkg::ST_NOT_EEPROM;
      else if (addr > sewf_pkg::ADDR_LIMIT) st = sewf_pkg::ST_PROTECTED;
      else if (!link_up) st = sewf_pkg::ST_NOT_READY;
      else st = sewf_pkg::ST_OK;
      if (st != sewf_pkg::ST_OK) begin
        w.bus_byte = '0;
        w.frame_end = 1'b0;
        w.last = 1'b1;
        w.status = st;
        pending_words.push_back(w);
        return;
      end
      cmd = sewf_pkg::CMD_EEPROM_BASE | {4'h0, addr[3:0]};
      frame[0] = cmd;
      frame[1] = 8'h00;
      frame[2] = 8'h00;
      frame[3] = pec(cmd, 8'h00, 8'h00);
      frame[4] = cmd;
      frame[5] = value[7:0];
      frame[6] = value[15:8];
      frame[7] = pec(cmd, value[7:0], value[15:8]);
      for (int k = 0; k < 8; k++) begin
        w.bus_byte = frame[k];
        w.frame_end = (k == 3 || k == 7);
        w.last = (k == 7);
        w.status = sewf_pkg::ST_OK;
        pending_words.push_back(w);
      end
    endfunction

    function void check_word(byte_t bus_byte, logic frame_end, logic last,
                             logic [sewf_pkg::STATUS_W-1:0] status);
      bus_word_t exp_w;
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: byte %02h end %0b last %0b status %0d",
                   bus_byte, frame_end, last, status);
        return;
      end
      exp_w = pending_words.pop_front();
      if (bus_byte !== exp_w.bus_byte || frame_end !== exp_w.frame_end ||
          last !== exp_w.last || status !== exp_w.status) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected %02h/%0b/%0b/%0d, got %02h/%0b/%0b/%0d",
                   exp_w.bus_byte, exp_w.frame_end, exp_w.last, exp_w.status,
                   bus_byte, frame_end, last, status);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [sewf_pkg::CFG_IDX_W-1:0]  cfg_index;
  cfg_word_t                       cfg_data;

  sewf_req_if req();
  sewf_res_if res();

  write_frame_ledger ledger;
  bit                quiet_sender;
  bit                quiet_sink;
  int unsigned       sink_hold = 0;
  int unsigned       idle_cycles = 0;

  smbus_eeprom_write_framer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned pick_gap(bit quiet, int unsigned idle_pct);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99, 0);
    if (r >= idle_pct) return 0;
    if (r < 4) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  always @(posedge clk) begin
    if (sink_hold == 0) sink_hold = pick_gap(quiet_sink, 25);
    if (sink_hold == 0) begin
      res.ready <= 1'b1;
    end else begin
      res.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1)
      ledger.check_word(res.bus_byte, res.frame_end, res.last, res.status);
    if (rst || (req.valid === 1'b1 && req.ready === 1'b1) ||
        (res.valid === 1'b1 && res.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic kind, input addr_t addr, input value_t value);
    int unsigned gap;
    gap = pick_gap(quiet_sender, 35);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.access_kind <= kind;
    req.word_address <= addr;
    req.word_value <= value;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    ledger.note_request(kind, addr, value);
  endtask

  task automatic drain_requests();
    req.valid <= 1'b0;
    while (ledger.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input sewf_pkg::cfg_reg_t which, input cfg_word_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    case (which)
      sewf_pkg::REG_DEVICE_ADDRESS: ledger.dev_addr = value[sewf_pkg::DEV_ADDR_W-1:0];
      sewf_pkg::REG_SENSOR_READY:   ledger.link_up = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_request();
    logic   kind;
    addr_t  addr;
    value_t value;
    if ($urandom_range(99, 0) < 75) begin
      kind = 1'b0;
      addr = addr_t'($urandom_range(3, 0));
    end else begin
      kind = 1'($urandom_range(1, 0));
      addr = addr_t'($urandom_range(255, 0));
    end
    value = value_t'($urandom());
    send_request(kind, addr, value);
  endtask

  initial begin
    dev_t      dev;
    cfg_word_t ready_word;
    ledger = new();
    quiet_sender = 1'b0;
    quiet_sink = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= sewf_pkg::REG_DEVICE_ADDRESS;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.access_kind <= 1'b0;
    req.word_address <= '0;
    req.word_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Straight out of reset the link is down, and the faults are reported in priority order.
    send_request(1'b0, 8'h00, 16'h1234);
    send_request(1'b1, 8'h05, 16'hFFFF);
    send_request(1'b0, 8'h04, 16'h0000);
    send_request(1'b1, 8'hFF, 16'h8001);
    drain_requests();

    write_reg(sewf_pkg::REG_DEVICE_ADDRESS, 7'h7F);
    write_reg(sewf_pkg::REG_SENSOR_READY, 7'h01);
    send_request(1'b0, 8'h00, 16'h0000);
    send_request(1'b0, 8'h01, 16'hFFFF);
    send_request(1'b0, 8'h02, 16'h00FF);
    send_request(1'b0, 8'h03, 16'hFF00);
    send_request(1'b0, 8'h03, 16'hA55A);
    send_request(1'b0, 8'h04, 16'hFFFF);
    send_request(1'b0, 8'hFF, 16'h0000);
    send_request(1'b0, 8'h80, 16'h7E81);
    send_request(1'b1, 8'h00, 16'h1111);
    send_request(1'b1, 8'h03, 16'hFFFF);
    drain_requests();

    write_reg(sewf_pkg::REG_DEVICE_ADDRESS, 7'h00);
    send_request(1'b0, 8'h00, 16'hFFFF);
    send_request(1'b0, 8'h03, 16'h0000);
    send_request(1'b0, 8'h02, 16'h5AA5);
    drain_requests();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      dev = (p == 0) ? 7'h7F : (p == 1) ? 7'h00 : dev_t'($urandom_range(127, 0));
      ready_word = cfg_word_t'($urandom_range(127, 0));
      ready_word[0] = (p != 5);
      if ($urandom_range(1, 0)) begin
        write_reg(sewf_pkg::REG_SENSOR_READY, ready_word);
        write_reg(sewf_pkg::REG_DEVICE_ADDRESS, dev);
      end else begin
        write_reg(sewf_pkg::REG_DEVICE_ADDRESS, dev);
        write_reg(sewf_pkg::REG_SENSOR_READY, ready_word);
      end
      quiet_sender = (p % 3 == 2);
      quiet_sink = (p % 4 == 3);
      repeat (PHASE_ITEMS) send_random_request();
      drain_requests();
    end

    if (ledger.mismatch_count == 0 && ledger.pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sewf_pkg.sv
sv/sewf_if.sv
sv/sewf_front.sv
sv/sewf_queue.sv
sv/sewf_back.sv
sv/smbus_eeprom_write_framer.sv
test/smbus_eeprom_write_framer_test.sv
